// ===== hw/rtl/dsa_pkg.sv =====
package dsa_pkg;

  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned STRIDE_W  = 13;
  localparam int unsigned SIZE_W    = 11;
  localparam int unsigned OUT_IDX_W = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned STATUS_W  = 2;

  // Offsets that pass the heap bound are below size * stride, which fits here.
  localparam int unsigned DIVD_W = SIZE_W + STRIDE_W;
  localparam int unsigned QUO_W  = SIZE_W;
  localparam int unsigned STEP_W = $clog2(QUO_W);

  localparam int unsigned SIZE_MAX = (1 << SIZE_W) - 1;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_ROOM    = 2'd1,
    ST_OUTSIDE    = 2'd2,
    ST_QUEUE_FULL = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAP_BASE    = 2'd0,
    CFG_SLOT_STRIDE  = 2'd1,
    CFG_SLOTS_IN_USE = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC,
    S_MUL,
    S_ADD,
    S_FSUB,
    S_FCHK,
    S_FDIV,
    S_FWR,
    S_OUT
  } state_t;

  localparam logic [ADDR_W-1:0]   HEAP_BASE_RST    = '0;
  localparam logic [STRIDE_W-1:0] SLOT_STRIDE_RST  = 13'd32;
  localparam logic [SIZE_W-1:0]   SLOTS_IN_USE_RST = 11'd1024;

endpackage

// ===== hw/rtl/dsa_if.sv =====
interface dsa_in_if
  import dsa_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [ADDR_W-1:0] slot_address;

  modport source (output valid, operation, slot_address, input ready);
  modport sink   (input valid, operation, slot_address, output ready);
endinterface

interface dsa_out_if
  import dsa_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [ADDR_W-1:0]    granted_address;
  logic [OUT_IDX_W-1:0] slot_index;
  logic [STATUS_W-1:0]  status;

  modport source (output valid, granted_address, slot_index, status, input ready);
  modport sink   (input valid, granted_address, slot_index, status, output ready);
endinterface

// ===== hw/rtl/dsa_ram.sv =====
module dsa_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/dsa_div.sv =====
module dsa_div
  import dsa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DIVD_W-1:0]   dividend,
  input  logic [STRIDE_W-1:0] divisor,
  output logic                done,
  output logic [QUO_W-1:0]    quotient
);

  logic [DIVD_W-1:0] rem_r;
  logic [DIVD_W-1:0] dvs_r;
  logic [QUO_W-1:0]  quo_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic              ge;

  // The caller guarantees the quotient fits in QUO_W bits, so the divisor
  // starts aligned to the top quotient bit and moves down one bit per cycle.
  assign ge = (rem_r >= dvs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= dividend;
      dvs_r  <= DIVD_W'({divisor, {(QUO_W-1){1'b0}}});
      quo_r  <= '0;
      step_r <= STEP_W'(QUO_W - 1);
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dvs_r;
      end
      quo_r  <= {quo_r[QUO_W-2:0], ge};
      dvs_r  <= dvs_r >> 1;
      step_r <= step_r - 1'b1;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== hw/rtl/descriptor_slot_allocator.sv =====
// Slot allocator for a descriptor heap. Each input transaction is an allocate
// or a free and yields exactly one result transaction. Allocation reuses the
// oldest freed index from a free queue held in a single-port-write RAM of
// HEAP_DEPTH entries, otherwise it hands out the next never-used index; the
// granted address is heap_base + index * slot_stride. A free subtracts the
// base, checks the offset against slots * stride and divides by the stride
// with a bit-serial divider (one quotient bit per cycle), then
// queues the index. One transaction is worked on at a time. An allocate
// steps through the alloc, multiply and add states to the output state, or
// from alloc straight to output when it fails; a free steps through subtract,
// check, divide, write and output, or from check to output when rejected.
// The divider sets the free rate. The input is ready again on the cycle after
// the result register loads, and the next input is taken while a result still
// waits on the output, but a finished result stalls until the output register
// is free. Configuration may be written only while the block is idle.
module descriptor_slot_allocator
  import dsa_pkg::*;
#(
  parameter int unsigned HEAP_DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  dsa_in_if.sink               in_chan,
  dsa_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_wdata
);

  localparam int unsigned IDX_W     = $clog2(HEAP_DEPTH);
  localparam int unsigned CNT_W     = IDX_W + 1;
  localparam int unsigned CMP_W     = (IDX_W > SIZE_W) ? IDX_W : SIZE_W;
  localparam int unsigned DEPTH_CAP = (HEAP_DEPTH > SIZE_MAX) ? SIZE_MAX : HEAP_DEPTH;

  // Configuration registers.
  logic [ADDR_W-1:0]   heap_base_r;
  logic [STRIDE_W-1:0] slot_stride_r;
  logic [SIZE_W-1:0]   slots_in_use_r;

  // Queue and fresh-counter control.
  logic [IDX_W-1:0]  head_r;
  logic [IDX_W-1:0]  tail_r;
  logic [CNT_W-1:0]  count_r;
  logic [SIZE_W-1:0] fresh_r;

  state_t state_r, state_nxt;

  // Datapath.
  logic [ADDR_W-1:0]    addr_r;
  logic [ADDR_W:0]      diff_r;
  logic [DIVD_W-1:0]    prod_r;
  logic [SIZE_W-1:0]    mul_idx_r;
  logic [ADDR_W-1:0]    res_addr_r;
  logic [OUT_IDX_W-1:0] res_idx_r;
  status_t              res_status_r;

  // Output register.
  logic                 out_valid_r;
  logic [ADDR_W-1:0]    out_addr_r;
  logic [OUT_IDX_W-1:0] out_idx_r;
  status_t              out_status_r;

  logic [SIZE_W-1:0] eff_size;
  logic [IDX_W-1:0]  ram_rdata;
  logic              ram_we;
  logic              q_nonempty;
  logic              q_full;
  logic              q_idx_big;
  logic              fresh_full;
  logic              alloc_fail;
  logic              free_bad;
  logic              in_fire;
  logic              out_free;
  logic              div_start;
  logic              div_done;
  logic [QUO_W-1:0]  div_quo;

  assign eff_size = (slots_in_use_r > SIZE_W'(DEPTH_CAP)) ? SIZE_W'(DEPTH_CAP)
                                                          : slots_in_use_r;

  assign q_nonempty = (count_r != '0);
  assign q_full     = (count_r == CNT_W'(HEAP_DEPTH));
  assign q_idx_big  = (CMP_W'(ram_rdata) >= CMP_W'(eff_size));
  assign fresh_full = (fresh_r >= eff_size);
  assign alloc_fail = q_nonempty ? q_idx_big : fresh_full;
  assign free_bad   = (slot_stride_r == '0) || diff_r[ADDR_W] ||
                      (diff_r[ADDR_W-1:0] >= ADDR_W'(prod_r));

  assign in_chan.ready = (state_r == S_IDLE) && rst_n;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;
  assign div_start     = (state_r == S_FCHK) && !free_bad;
  assign ram_we        = (state_r == S_FWR) && !q_full;

  // The queue read that is used is the one at acceptance, and the write comes only
  // near the end of a free, with one transaction in flight, so the two never touch at once.
  dsa_ram #(
    .WIDTH(IDX_W),
    .DEPTH(HEAP_DEPTH)
  ) u_free_queue (
    .clk  (clk),
    .we   (ram_we),
    .waddr(tail_r),
    .wdata(IDX_W'(div_quo)),
    .raddr(head_r),
    .rdata(ram_rdata)
  );

  dsa_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(diff_r[DIVD_W-1:0]),
    .divisor (slot_stride_r),
    .done    (div_done),
    .quotient(div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (op_t'(in_chan.operation) == OP_FREE) ? S_FSUB : S_ALLOC;
        end
      end
      S_ALLOC: state_nxt = alloc_fail ? S_OUT : S_MUL;
      S_MUL:   state_nxt = S_ADD;
      S_ADD:   state_nxt = S_OUT;
      S_FSUB:  state_nxt = S_FCHK;
      S_FCHK:  state_nxt = free_bad ? S_OUT : S_FDIV;
      S_FDIV: begin
        if (div_done) begin
          state_nxt = S_FWR;
        end
      end
      S_FWR: state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Configuration and queue control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r    <= HEAP_BASE_RST;
      slot_stride_r  <= SLOT_STRIDE_RST;
      slots_in_use_r <= SLOTS_IN_USE_RST;
      head_r         <= '0;
      tail_r         <= '0;
      count_r        <= '0;
      fresh_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_HEAP_BASE:    heap_base_r    <= cfg_wdata;
          CFG_SLOT_STRIDE:  slot_stride_r  <= cfg_wdata[STRIDE_W-1:0];
          CFG_SLOTS_IN_USE: slots_in_use_r <= cfg_wdata[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_ALLOC) begin
        if (q_nonempty) begin
          // A popped index that no longer fits is dropped.
          head_r  <= (head_r == IDX_W'(HEAP_DEPTH - 1)) ? '0 : head_r + 1'b1;
          count_r <= count_r - 1'b1;
        end else if (!fresh_full) begin
          fresh_r <= fresh_r + 1'b1;
        end
      end
      if (ram_we) begin
        tail_r  <= (tail_r == IDX_W'(HEAP_DEPTH - 1)) ? '0 : tail_r + 1'b1;
        count_r <= count_r + 1'b1;
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        addr_r <= in_chan.slot_address;
      end
      S_ALLOC: begin
        res_addr_r   <= '0;
        res_status_r <= alloc_fail ? ST_NO_ROOM : ST_OK;
        if (q_nonempty) begin
          res_idx_r <= OUT_IDX_W'(ram_rdata);
          mul_idx_r <= SIZE_W'(ram_rdata);
        end else begin
          res_idx_r <= fresh_full ? '0 : OUT_IDX_W'(fresh_r);
          mul_idx_r <= fresh_r;
        end
      end
      S_MUL: begin
        prod_r <= DIVD_W'(mul_idx_r * slot_stride_r);
      end
      S_ADD: begin
        res_addr_r <= heap_base_r + ADDR_W'(prod_r);
      end
      S_FSUB: begin
        diff_r <= {1'b0, addr_r} - {1'b0, heap_base_r};
        prod_r <= DIVD_W'(eff_size * slot_stride_r);
      end
      S_FCHK: begin
        res_addr_r   <= '0;
        res_idx_r    <= '0;
        res_status_r <= ST_OUTSIDE;
      end
      S_FWR: begin
        res_idx_r    <= OUT_IDX_W'(div_quo);
        res_status_r <= q_full ? ST_QUEUE_FULL : ST_OK;
      end
      S_OUT: begin
        if (out_free) begin
          out_addr_r   <= res_addr_r;
          out_idx_r    <= res_idx_r;
          out_status_r <= res_status_r;
        end
      end
      default: ;
    endcase
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.granted_address = out_addr_r;
  assign out_chan.slot_index      = out_idx_r;
  assign out_chan.status          = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(HEAP_DEPTH))
    else $error("free queue count exceeds its depth");

  a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r <= SIZE_W'(DEPTH_CAP))
    else $error("fresh counter ran past the heap");

  a_err_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && status_t'(out_chan.status) != ST_OK) |->
      (out_chan.granted_address == '0))
    else $error("failed transaction carries a nonzero address");

  a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_FDIV))
    else $error("divider finished outside the divide state");

  a_ram_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ($past(state_r) == S_FDIV && $past(div_done)))
    else $error("queue written without a completed divide");

endmodule
